>>> rtl/core/gcode_line_word_parser_top_defines.svh
// ------------------------------------------------------------------------------------------
// gcode_line_word_parser_top_defines.svh
// Assertion macros for the G-code line word parser. Empty bodies when SYNTHESIS is set.
// ------------------------------------------------------------------------------------------
`ifndef GCODE_LINE_WORD_PARSER_TOP_DEFINES_SVH
`define GCODE_LINE_WORD_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant or implication checked at every clock edge outside reset.
`define GCLWP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gclwp assertion failed");
// Antecedent this cycle, consequent at the next edge.
`define GCLWP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gclwp assertion failed");
`else
`define GCLWP_ASSERT(lbl, prop)
`define GCLWP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/gclwp_pkg.sv
// ------------------------------------------------------------------------------------------
// gclwp_pkg
// Shared types, character codes and helpers for the G-code line word parser.
// ------------------------------------------------------------------------------------------
package gclwp_pkg;

	// number format
	localparam int FracDigits = 3;
	localparam int ValueBits  = 32;
	localparam int MagW       = ValueBits;
	localparam int FcW        = (FracDigits > 0) ? $clog2(FracDigits + 1) : 1;
	localparam longint unsigned Scale = 64'd10 ** FracDigits;
	localparam int ScaleW     = $clog2(Scale + 1);
	localparam int ProdW      = MagW + ScaleW;
	localparam logic [MagW-1:0] Cap = {1'b1, {(MagW-1){1'b0}}};

	// result words
	localparam int WordW    = 32;
	localparam int NumWords = 6;
	localparam int SlotX = 0;
	localparam int SlotY = 1;
	localparam int SlotZ = 2;
	localparam int SlotF = 3;
	localparam int SlotS = 4;
	localparam int SlotP = 5;

	// character codes
	localparam logic [7:0] ChSemi  = 8'h3B;
	localparam logic [7:0] ChParen = 8'h28;
	localparam logic [7:0] ChPoint = 8'h2E;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowZ  = 8'h7A;
	localparam logic [7:0] CaseGap = 8'h20;
	localparam logic [7:0] ChG = 8'h47;
	localparam logic [7:0] ChM = 8'h4D;
	localparam logic [7:0] ChX = 8'h58;
	localparam logic [7:0] ChY = 8'h59;
	localparam logic [7:0] ChZ = 8'h5A;
	localparam logic [7:0] ChF = 8'h46;
	localparam logic [7:0] ChS = 8'h53;
	localparam logic [7:0] ChP = 8'h50;

	// G and M code numbers
	localparam int NumG0   = 0;
	localparam int NumG1   = 1;
	localparam int NumG4   = 4;
	localparam int NumG21  = 21;
	localparam int NumG28  = 28;
	localparam int NumG90  = 90;
	localparam int NumG91  = 91;
	localparam int NumG92  = 92;
	localparam int NumM3   = 3;
	localparam int NumM3L  = 300;
	localparam int NumM5   = 5;
	localparam int NumM5L  = 500;
	localparam int NumM112 = 112;

	typedef enum logic [1:0] {
		PH_LETTER,
		PH_SKIPWS,
		PH_NUMBER
	} phase_t;

	typedef enum logic [3:0] {
		LT_OTHER,
		LT_G,
		LT_M,
		LT_X,
		LT_Y,
		LT_Z,
		LT_F,
		LT_S,
		LT_P
	} letter_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_G0,
		CMD_G1,
		CMD_G4,
		CMD_G21,
		CMD_G28,
		CMD_G90,
		CMD_G91,
		CMD_G92,
		CMD_M3,
		CMD_M5,
		CMD_M112,
		CMD_UNKNOWN
	} cmd_t;

	// word in progress, handed to the finish logic
	typedef struct packed {
		logic [FcW-1:0]  frac_cnt;
		logic [MagW-1:0] mag;
		logic            neg;
		logic            nz;
		letter_t         letter;
		cmd_t            cmd;
	} word_state_t;

	// what closing a word does to the line
	typedef struct packed {
		cmd_t                cmd;
		logic [NumWords-1:0] slot_we;
		logic [WordW-1:0]    value;
	} finish_t;

	function automatic letter_t letter_code(input logic [7:0] c);
		letter_t l;
		case (c)
			ChG:     l = LT_G;
			ChM:     l = LT_M;
			ChX:     l = LT_X;
			ChY:     l = LT_Y;
			ChZ:     l = LT_Z;
			ChF:     l = LT_F;
			ChS:     l = LT_S;
			ChP:     l = LT_P;
			default: l = LT_OTHER;
		endcase
		return l;
	endfunction

	// 10 ** (FracDigits - fc): pads missing fraction digits
	function automatic logic [ScaleW-1:0] pad_scale(input logic [FcW-1:0] fc);
		longint unsigned s;
		s = 1;
		for (int k = 0; k < FracDigits; k++) begin
			if (k >= int'(fc)) begin
				s = s * 10;
			end
		end
		return ScaleW'(s);
	endfunction

endpackage

>>> rtl/core/gclwp_finish.sv
// ------------------------------------------------------------------------------------------
// gclwp_finish
// Closes one word: pads the fraction, saturates, forms the signed value and decodes G/M.
// ------------------------------------------------------------------------------------------
module gclwp_finish (
	input  gclwp_pkg::word_state_t ws,
	output gclwp_pkg::finish_t     fin
);

	logic [gclwp_pkg::ProdW-1:0] prod;
	logic [gclwp_pkg::MagW-1:0]  mag_pad;
	logic [gclwp_pkg::MagW-1:0]  bits;
	logic [63:0]                 mag_wide;
	logic                        code_ok;

	// integer part of the padded magnitude equals n
	function automatic logic in_band(input logic [63:0] m, input int n);
		return (m >= 64'(n) * gclwp_pkg::Scale) && (m < 64'(n + 1) * gclwp_pkg::Scale);
	endfunction

	always_comb begin
		prod = gclwp_pkg::ProdW'(ws.mag) *
			gclwp_pkg::ProdW'(gclwp_pkg::pad_scale(ws.frac_cnt));
		mag_pad = (prod > gclwp_pkg::ProdW'(gclwp_pkg::Cap)) ? gclwp_pkg::Cap
			: gclwp_pkg::MagW'(prod);
		if (ws.neg) begin
			bits = gclwp_pkg::MagW'(0) - mag_pad;
		end else begin
			bits = (mag_pad < gclwp_pkg::Cap) ? mag_pad
				: gclwp_pkg::Cap - gclwp_pkg::MagW'(1);
		end
		mag_wide = 64'(mag_pad);
		code_ok  = !(ws.neg && (mag_wide >= gclwp_pkg::Scale));
	end

	always_comb begin
		fin.cmd     = ws.cmd;
		fin.slot_we = '0;
		fin.value   = gclwp_pkg::WordW'($signed(bits));
		case (ws.letter)
			gclwp_pkg::LT_G: begin
				if (!code_ok)                                fin.cmd = gclwp_pkg::CMD_UNKNOWN;
				else if (in_band(mag_wide, gclwp_pkg::NumG0))  fin.cmd = gclwp_pkg::CMD_G0;
				else if (in_band(mag_wide, gclwp_pkg::NumG1))  fin.cmd = gclwp_pkg::CMD_G1;
				else if (in_band(mag_wide, gclwp_pkg::NumG4))  fin.cmd = gclwp_pkg::CMD_G4;
				else if (in_band(mag_wide, gclwp_pkg::NumG21)) fin.cmd = gclwp_pkg::CMD_G21;
				else if (in_band(mag_wide, gclwp_pkg::NumG28)) fin.cmd = gclwp_pkg::CMD_G28;
				else if (in_band(mag_wide, gclwp_pkg::NumG90)) fin.cmd = gclwp_pkg::CMD_G90;
				else if (in_band(mag_wide, gclwp_pkg::NumG91)) fin.cmd = gclwp_pkg::CMD_G91;
				else if (in_band(mag_wide, gclwp_pkg::NumG92)) fin.cmd = gclwp_pkg::CMD_G92;
				else                                           fin.cmd = gclwp_pkg::CMD_UNKNOWN;
			end
			gclwp_pkg::LT_M: begin
				if (!code_ok) begin
					fin.cmd = gclwp_pkg::CMD_UNKNOWN;
				end else if (in_band(mag_wide, gclwp_pkg::NumM3)
						|| in_band(mag_wide, gclwp_pkg::NumM3L)) begin
					fin.cmd = gclwp_pkg::CMD_M3;
				end else if (in_band(mag_wide, gclwp_pkg::NumM5)
						|| in_band(mag_wide, gclwp_pkg::NumM5L)) begin
					fin.cmd = gclwp_pkg::CMD_M5;
				end else if (in_band(mag_wide, gclwp_pkg::NumM112)) begin
					fin.cmd = gclwp_pkg::CMD_M112;
				end else begin
					fin.cmd = gclwp_pkg::CMD_UNKNOWN;
				end
			end
			gclwp_pkg::LT_X: fin.slot_we[gclwp_pkg::SlotX] = 1'b1;
			gclwp_pkg::LT_Y: fin.slot_we[gclwp_pkg::SlotY] = 1'b1;
			gclwp_pkg::LT_Z: begin
				fin.slot_we[gclwp_pkg::SlotZ] = 1'b1;
				// lone Z: spindle on if truly negative, otherwise off
				if (ws.cmd == gclwp_pkg::CMD_NONE) begin
					fin.cmd = (ws.neg && ws.nz) ? gclwp_pkg::CMD_M3 : gclwp_pkg::CMD_M5;
				end
			end
			gclwp_pkg::LT_F: fin.slot_we[gclwp_pkg::SlotF] = 1'b1;
			gclwp_pkg::LT_S: fin.slot_we[gclwp_pkg::SlotS] = 1'b1;
			gclwp_pkg::LT_P: fin.slot_we[gclwp_pkg::SlotP] = 1'b1;
			default: ;
		endcase
	end

endmodule

>>> rtl/core/gcode_line_word_parser_top.sv
// ------------------------------------------------------------------------------------------
// gcode_line_word_parser_top
// Parses one G-code line, a byte per item, into command type, presence mask and six values.
// ------------------------------------------------------------------------------------------
// Usage:
//  - Character channel: ch, end_of_line with char_valid / char_stall. One byte per item;
//    an item with end_of_line set closes the line (its ch is ignored).
//  - Result channel: cmd_type, present_mask and x/y/z/f/s/p_value with result_valid /
//    result_stall. Exactly one result per end_of_line item, none for ordinary bytes.
//  - Values are signed thousandths; absent words read as zero.
//  - Throughput: one item per clock, sustained while result_stall is low, any byte pattern.
//  - Path: input register, then one pass of decode, multiply-by-ten accumulate or word
//    close (fraction padding multiply, saturation, G/M decode), then the result register.
//  - When result_stall holds a waiting result, the input register still takes one more
//    item; char_stall rises only when both registers are full.
//  - Reset (arst_n low) empties both registers and clears the line state; the parser then
//    waits for the first letter of a fresh line.
// ------------------------------------------------------------------------------------------
`include "gcode_line_word_parser_top_defines.svh"

module gcode_line_word_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          ch,
	input  logic                end_of_line,
	input  logic                char_valid,
	output logic                char_stall,
	output logic [3:0]          cmd_type,
	output logic [5:0]          present_mask,
	output logic signed [31:0]  x_value,
	output logic signed [31:0]  y_value,
	output logic signed [31:0]  z_value,
	output logic signed [31:0]  f_value,
	output logic signed [31:0]  s_value,
	output logic signed [31:0]  p_value,
	output logic                result_valid,
	input  logic                result_stall
);

	localparam int PushW = gclwp_pkg::MagW + 4;

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eol_s1;

	// result register
	logic                                  valid_s2;
	gclwp_pkg::cmd_t                       cmd_s2;
	logic [gclwp_pkg::NumWords-1:0]        pres_s2;
	logic [gclwp_pkg::WordW-1:0]           val_s2 [gclwp_pkg::NumWords];

	// line state
	gclwp_pkg::phase_t              phase_q, phase_d;
	logic                           comment_q, comment_d;
	gclwp_pkg::letter_t             letter_q, letter_d;
	logic [gclwp_pkg::MagW-1:0]     mag_q, mag_d;
	logic                           neg_q, neg_d;
	logic                           point_q, point_d;
	logic                           stop_q, stop_d;
	logic [gclwp_pkg::FcW-1:0]      fc_q, fc_d;
	logic                           nz_q, nz_d;
	gclwp_pkg::cmd_t                cmd_q, cmd_d;
	logic [gclwp_pkg::NumWords-1:0] pres_q, pres_d;
	logic [gclwp_pkg::WordW-1:0]    word_q [gclwp_pkg::NumWords];

	logic                           advance;
	logic                           fire;
	logic [7:0]                     c;
	logic                           blank;
	logic                           numeric;
	logic                           finish_en;
	logic                           take_letter;
	logic                           take_num;
	logic [PushW-1:0]               push_sum;
	logic [gclwp_pkg::MagW-1:0]     push_mag;
	gclwp_pkg::word_state_t         ws;
	gclwp_pkg::finish_t             fin;
	gclwp_pkg::cmd_t                res_cmd;
	logic [gclwp_pkg::WordW-1:0]    res_val [gclwp_pkg::NumWords];

	// ---------------------------------------------------------------- handshake
	// the result register frees when empty or when its item is taken
	assign advance    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && advance;
	assign char_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			ch_s1  <= ch;
			eol_s1 <= end_of_line;
		end
	end

	// ---------------------------------------------------------------- byte decode
	always_comb begin
		c = ch_s1;
		if (ch_s1 >= gclwp_pkg::ChLowA && ch_s1 <= gclwp_pkg::ChLowZ) begin
			c = ch_s1 - gclwp_pkg::CaseGap;
		end
		blank   = (c == gclwp_pkg::ChSpace) || (c == gclwp_pkg::ChTab);
		numeric = (c >= gclwp_pkg::ChZero && c <= gclwp_pkg::ChNine)
			|| (c == gclwp_pkg::ChPoint) || (c == gclwp_pkg::ChMinus);
	end

	// acc * 10 + digit, saturating at the magnitude cap
	always_comb begin
		push_sum = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + PushW'(c[3:0]);
		push_mag = (push_sum > PushW'(gclwp_pkg::Cap)) ? gclwp_pkg::Cap
			: gclwp_pkg::MagW'(push_sum);
	end

	// ---------------------------------------------------------------- word close
	assign ws = '{frac_cnt: fc_q, mag: mag_q, neg: neg_q, nz: nz_q,
		letter: letter_q, cmd: cmd_q};

	gclwp_finish u_finish (
		.ws  (ws),
		.fin (fin)
	);

	// ---------------------------------------------------------------- next state
	always_comb begin
		phase_d     = phase_q;
		comment_d   = comment_q;
		letter_d    = letter_q;
		mag_d       = mag_q;
		neg_d       = neg_q;
		point_d     = point_q;
		stop_d      = stop_q;
		fc_d        = fc_q;
		nz_d        = nz_q;
		cmd_d       = cmd_q;
		pres_d      = pres_q;
		finish_en   = 1'b0;
		take_letter = 1'b0;
		take_num    = 1'b0;

		if (eol_s1) begin
			finish_en = (phase_q != gclwp_pkg::PH_LETTER);
		end else if (!comment_q) begin
			if (c == gclwp_pkg::ChSemi || c == gclwp_pkg::ChParen) begin
				finish_en = (phase_q != gclwp_pkg::PH_LETTER);
				comment_d = 1'b1;
			end else if (phase_q == gclwp_pkg::PH_LETTER) begin
				take_letter = 1'b1;
			end else if (phase_q == gclwp_pkg::PH_SKIPWS && blank) begin
				// blanks between letter and number
			end else if (numeric) begin
				take_num = 1'b1;
			end else begin
				finish_en   = 1'b1;
				take_letter = 1'b1;
			end
		end

		if (finish_en) begin
			cmd_d   = fin.cmd;
			pres_d  = pres_q | fin.slot_we;
			phase_d = gclwp_pkg::PH_LETTER;
		end

		if (take_letter && !blank) begin
			letter_d = gclwp_pkg::letter_code(c);
			mag_d    = '0;
			neg_d    = 1'b0;
			point_d  = 1'b0;
			stop_d   = 1'b0;
			fc_d     = '0;
			nz_d     = 1'b0;
			phase_d  = gclwp_pkg::PH_SKIPWS;
		end

		if (take_num) begin
			if (phase_q == gclwp_pkg::PH_SKIPWS) begin
				phase_d = gclwp_pkg::PH_NUMBER;
			end
			if (phase_q == gclwp_pkg::PH_SKIPWS && c == gclwp_pkg::ChMinus) begin
				neg_d = 1'b1;   // leading sign
			end else if (stop_q) begin
				// rest of the run is swallowed
			end else if (c == gclwp_pkg::ChMinus) begin
				stop_d = 1'b1;
			end else if (c == gclwp_pkg::ChPoint) begin
				if (point_q) begin
					stop_d = 1'b1;
				end else begin
					point_d = 1'b1;
				end
			end else begin
				if (c[3:0] != 4'd0) begin
					nz_d = 1'b1;
				end
				if (!point_q) begin
					mag_d = push_mag;
				end else if (int'(fc_q) < gclwp_pkg::FracDigits) begin
					mag_d = push_mag;
					fc_d  = fc_q + gclwp_pkg::FcW'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------- result
	always_comb begin
		res_cmd = cmd_d;
		if (cmd_d == gclwp_pkg::CMD_NONE
				&& (pres_d[gclwp_pkg::SlotX] || pres_d[gclwp_pkg::SlotY])) begin
			res_cmd = gclwp_pkg::CMD_G1;   // bare X/Y means linear move
		end
		for (int k = 0; k < gclwp_pkg::NumWords; k++) begin
			if (!pres_d[k]) begin
				res_val[k] = '0;
			end else if (finish_en && fin.slot_we[k]) begin
				res_val[k] = fin.value;
			end else begin
				res_val[k] = word_q[k];
			end
		end
	end

	// ---------------------------------------------------------------- state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= gclwp_pkg::PH_LETTER;
			comment_q <= 1'b0;
			letter_q  <= gclwp_pkg::LT_OTHER;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			point_q   <= 1'b0;
			stop_q    <= 1'b0;
			fc_q      <= '0;
			nz_q      <= 1'b0;
			cmd_q     <= gclwp_pkg::CMD_NONE;
			pres_q    <= '0;
		end else if (fire) begin
			if (eol_s1) begin
				phase_q   <= gclwp_pkg::PH_LETTER;
				comment_q <= 1'b0;
				letter_q  <= gclwp_pkg::LT_OTHER;
				mag_q     <= '0;
				neg_q     <= 1'b0;
				point_q   <= 1'b0;
				stop_q    <= 1'b0;
				fc_q      <= '0;
				nz_q      <= 1'b0;
				cmd_q     <= gclwp_pkg::CMD_NONE;
				pres_q    <= '0;
			end else begin
				phase_q   <= phase_d;
				comment_q <= comment_d;
				letter_q  <= letter_d;
				mag_q     <= mag_d;
				neg_q     <= neg_d;
				point_q   <= point_d;
				stop_q    <= stop_d;
				fc_q      <= fc_d;
				nz_q      <= nz_d;
				cmd_q     <= cmd_d;
				pres_q    <= pres_d;
			end
		end
	end

	// stored values are only read behind their presence bit
	always_ff @(posedge clk) begin
		for (int k = 0; k < gclwp_pkg::NumWords; k++) begin
			if (fire && finish_en && fin.slot_we[k]) begin
				word_q[k] <= fin.value;
			end
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && eol_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && eol_s1) begin
			cmd_s2  <= res_cmd;
			pres_s2 <= pres_d;
			for (int k = 0; k < gclwp_pkg::NumWords; k++) begin
				val_s2[k] <= res_val[k];
			end
		end
	end

	assign result_valid = valid_s2;
	assign cmd_type     = cmd_s2;
	assign present_mask = pres_s2;
	assign x_value      = $signed(val_s2[gclwp_pkg::SlotX]);
	assign y_value      = $signed(val_s2[gclwp_pkg::SlotY]);
	assign z_value      = $signed(val_s2[gclwp_pkg::SlotZ]);
	assign f_value      = $signed(val_s2[gclwp_pkg::SlotF]);
	assign s_value      = $signed(val_s2[gclwp_pkg::SlotS]);
	assign p_value      = $signed(val_s2[gclwp_pkg::SlotP]);

	// ---------------------------------------------------------------- assertions
	`GCLWP_ASSERT(a_stall_when_full, char_stall |-> (valid_s1 && valid_s2 && result_stall))
	`GCLWP_ASSERT_NEXT(a_eol_clears_line, (fire && eol_s1),
		(phase_q == gclwp_pkg::PH_LETTER && pres_q == '0 && !comment_q))
	`GCLWP_ASSERT_NEXT(a_no_result_mid_line, (fire && !eol_s1), !valid_s2)
	`GCLWP_ASSERT(a_z_sets_command, pres_q[gclwp_pkg::SlotZ] |-> (cmd_q != gclwp_pkg::CMD_NONE))
	`GCLWP_ASSERT(a_no_fraction_before_point, !point_q |-> (fc_q == '0))

endmodule
